[hdl/channel_frame_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// channel_frame_parser_core_defines
// Assertion macros shared by the channel frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_FRAME_PARSER_CORE_DEFINES_SVH
`define CHANNEL_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfp assertion failed");
// next-cycle implication
`define CFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfp assertion failed");
`else
`define CFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define CFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants for the channel frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int CHANNELS_DEFAULT = 16;

   localparam logic [7:0] SOF_FIRST  = 8'h01;
   localparam logic [7:0] SOF_SECOND = 8'h02;
   localparam logic [7:0] TRAILER_OK = 8'hDD;
   localparam logic [7:0] EOF_BYTE   = 8'hD4;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   typedef enum logic [2:0] {
      PARSE_HUNT    = 3'd0,
      PARSE_SECOND  = 3'd1,
      PARSE_COUNT   = 3'd2,
      PARSE_HIGH    = 3'd3,
      PARSE_LOW     = 3'd4,
      PARSE_TRAILER = 3'd5,
      PARSE_END     = 3'd6,
      PARSE_ERROR   = 3'd7
   } parse_state_type;

   typedef enum logic [1:0] {
      DRAIN_IDLE = 2'd0,
      DRAIN_READ = 2'd1,
      DRAIN_SHOW = 2'd2
   } drain_state_type;

endpackage

[hdl/cfp_req_if.sv]
// ----------------------------------------------------------------------------
// cfp_req_if
// Byte channel into the parser: valid/ready plus one received byte.
// ----------------------------------------------------------------------------
interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/cfp_rsp_if.sv]
// ----------------------------------------------------------------------------
// cfp_rsp_if
// Result channel out of the parser: one channel value per transfer.
// ----------------------------------------------------------------------------
interface cfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  channel_number;
   logic [11:0] channel_value;
   logic        last_channel;

   modport source (output valid, output channel_number, output channel_value,
                   output last_channel, input ready);
   modport sink   (input valid, input channel_number, input channel_value,
                   input last_channel, output ready);
endinterface

[hdl/cfp_ram.sv]
// ----------------------------------------------------------------------------
// cfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfp_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cfp_parser.sv]
// ----------------------------------------------------------------------------
// cfp_parser
// Byte-level frame parser: tracks the frame layout, stores each channel
// value and raises a commit strobe on a good end byte.
// ----------------------------------------------------------------------------
module cfp_parser #(
   parameter int CHANNELS = cfp_pkg::CHANNELS_DEFAULT,
   localparam int CNT_W  = $clog2(CHANNELS + 1),
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic [7:0]        in_byte,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [11:0]       wr_data,
   output logic              commit,
   output logic [CNT_W-1:0]  commit_count
);

   cfp_pkg::parse_state_type state_ff, state_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic [7:0]       low_ff, low_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] index_next;
   logic [7:0]       count_clamp;
   logic             last_seen;

   assign index_next = index_ff + CNT_W'(1);
   assign last_seen  = (index_next >= count_ff);

   always_comb begin
      if (in_byte == 8'd0) begin
         count_clamp = 8'd1;
      end else if (in_byte > 8'(CHANNELS)) begin
         count_clamp = 8'(CHANNELS);
      end else begin
         count_clamp = in_byte;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (in_fire) begin
         unique case (state_ff)
            cfp_pkg::PARSE_HUNT: begin
               state_in = (in_byte == cfp_pkg::SOF_FIRST) ? cfp_pkg::PARSE_SECOND
                                                          : cfp_pkg::PARSE_ERROR;
            end
            cfp_pkg::PARSE_SECOND: begin
               state_in = (in_byte == cfp_pkg::SOF_SECOND) ? cfp_pkg::PARSE_COUNT
                                                           : cfp_pkg::PARSE_ERROR;
            end
            cfp_pkg::PARSE_COUNT:   state_in = cfp_pkg::PARSE_HIGH;
            cfp_pkg::PARSE_HIGH:    state_in = cfp_pkg::PARSE_LOW;
            cfp_pkg::PARSE_LOW:     state_in = cfp_pkg::PARSE_TRAILER;
            cfp_pkg::PARSE_TRAILER: begin
               // trailer after the last channel is not checked
               if (last_seen) begin
                  state_in = cfp_pkg::PARSE_END;
               end else if (in_byte == cfp_pkg::TRAILER_OK) begin
                  state_in = cfp_pkg::PARSE_HIGH;
               end else begin
                  state_in = cfp_pkg::PARSE_ERROR;
               end
            end
            cfp_pkg::PARSE_END: begin
               state_in = (in_byte == cfp_pkg::EOF_BYTE) ? cfp_pkg::PARSE_HUNT
                                                         : cfp_pkg::PARSE_ERROR;
            end
            cfp_pkg::PARSE_ERROR:   state_in = cfp_pkg::PARSE_HUNT;
            default:                state_in = cfp_pkg::PARSE_HUNT;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      nibble_in = nibble_ff;
      low_in    = low_ff;
      index_in  = index_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      commit    = 1'b0;
      if (in_fire) begin
         unique case (state_ff)
            cfp_pkg::PARSE_COUNT: count_in  = CNT_W'(count_clamp);
            cfp_pkg::PARSE_HIGH:  nibble_in = 4'(in_byte & cfp_pkg::NIBBLE_MASK);
            cfp_pkg::PARSE_LOW:   low_in    = in_byte;
            cfp_pkg::PARSE_TRAILER: begin
               wr_en     = 1'b1;
               nibble_in = 4'd0;
               low_in    = 8'd0;
               index_in  = last_seen ? '0 : index_next;
            end
            cfp_pkg::PARSE_END:   commit = (in_byte == cfp_pkg::EOF_BYTE);
            cfp_pkg::PARSE_ERROR: begin
               nibble_in = 4'd0;
               low_in    = 8'd0;
               index_in  = '0;
            end
            default: ;
         endcase
      end
   end

   assign wr_addr      = index_ff[ADDR_W-1:0];
   assign wr_data      = {nibble_ff, low_ff};
   assign commit_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cfp_pkg::PARSE_HUNT;
         nibble_ff <= 4'd0;
         low_ff    <= 8'd0;
         index_ff  <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         nibble_ff <= nibble_in;
         low_ff    <= low_in;
         index_ff  <= index_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/cfp_drain.sv]
// ----------------------------------------------------------------------------
// cfp_drain
// Commit sequencer: walks the value store one channel at a time and hands
// each value out on the result channel.
// ----------------------------------------------------------------------------
`include "channel_frame_parser_core_defines.svh"

module cfp_drain #(
   parameter int CHANNELS = cfp_pkg::CHANNELS_DEFAULT,
   localparam int CNT_W  = $clog2(CHANNELS + 1),
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int NUM_W  = (CNT_W > 5) ? CNT_W : 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  logic [CNT_W-1:0]  commit_count,
   output logic              busy,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [11:0]       rd_data,
   cfp_rsp_if.source         rsp
);

   cfp_pkg::drain_state_type state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_next;
   logic [NUM_W-1:0] number;
   logic             is_last;
   logic             fire;

   assign idx_next = idx_ff + CNT_W'(1);
   assign is_last  = (idx_next == cnt_ff);
   assign number   = NUM_W'(idx_ff) + NUM_W'(1);
   assign fire     = rsp.valid && rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfp_pkg::DRAIN_IDLE: if (commit) state_in = cfp_pkg::DRAIN_READ;
         cfp_pkg::DRAIN_READ: state_in = cfp_pkg::DRAIN_SHOW;
         cfp_pkg::DRAIN_SHOW: begin
            if (fire) begin
               state_in = is_last ? cfp_pkg::DRAIN_IDLE : cfp_pkg::DRAIN_READ;
            end
         end
         default: state_in = cfp_pkg::DRAIN_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      rd_en     = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         cfp_pkg::DRAIN_IDLE: begin
            if (commit) begin
               idx_in = '0;
               cnt_in = commit_count;
            end
         end
         cfp_pkg::DRAIN_READ: rd_en = 1'b1;
         cfp_pkg::DRAIN_SHOW: begin
            rsp.valid = 1'b1;
            if (fire && !is_last) begin
               idx_in = idx_next;
            end
         end
         default: ;
      endcase
   end

   assign busy               = (state_ff != cfp_pkg::DRAIN_IDLE);
   assign rd_addr            = idx_ff[ADDR_W-1:0];
   assign rsp.channel_number = number[4:0];
   assign rsp.channel_value  = rd_data;
   assign rsp.last_channel   = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfp_pkg::DRAIN_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   `CFP_ASSERT_SAME(a_idx_in_range, clock, reset, busy, idx_ff < cnt_ff)
   `CFP_ASSERT_SAME(a_no_commit_when_busy, clock, reset, busy, !commit)
   `CFP_ASSERT_NEXT(a_commit_starts_read, clock, reset, commit, state_ff == cfp_pkg::DRAIN_READ)
   `CFP_ASSERT_NEXT(a_stall_holds_idx, clock, reset, rsp.valid && !rsp.ready, $stable(idx_ff) && state_ff == cfp_pkg::DRAIN_SHOW)

endmodule

[hdl/channel_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// channel_frame_parser_core
// Byte-serial multi-channel frame parser with a committed-value drain.
// ----------------------------------------------------------------------------
// While parsing, the block takes one byte per cycle. On a good end byte it
// stops taking bytes and plays out the frame's channel values from the value
// store: each result is one RAM read with registered data, then the result
// is held until transferred, so req stays held off until every channel of
// the frame is transferred, output stalls included. The value store is a
// CHANNELS-deep RAM with one write and one read port and needs no clearing.
// Results carry a 1-based channel number and a mark on the last one.
`include "channel_frame_parser_core_defines.svh"

module channel_frame_parser_core #(
   parameter int CHANNELS = cfp_pkg::CHANNELS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cfp_req_if.sink   req_if,
   cfp_rsp_if.source rsp_if
);

   localparam int CNT_W  = $clog2(CHANNELS + 1);
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic              in_fire;
   logic              busy;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [11:0]       wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [11:0]       rd_data;
   logic              commit;
   logic [CNT_W-1:0]  commit_count;

   assign req_if.ready = !busy;
   assign in_fire      = req_if.valid && req_if.ready;

   cfp_parser #(.CHANNELS(CHANNELS)) u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (in_fire),
      .in_byte      (req_if.rx_byte),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .commit       (commit),
      .commit_count (commit_count)
   );

   cfp_ram #(.WIDTH(12), .DEPTH(CHANNELS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfp_drain #(.CHANNELS(CHANNELS)) u_drain (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .commit_count (commit_count),
      .busy         (busy),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp          (rsp_if)
   );

   // no byte transfer while a result is on offer
   `CFP_ASSERT_SAME(a_rsp_blocks_req, clock, reset, rsp_if.valid, !req_if.ready)
   // no store write during a drain
   `CFP_ASSERT_SAME(a_no_write_in_drain, clock, reset, busy, !wr_en)

endmodule

[test/tb_channel_frame_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_frame_parser_core
// Self-checking bench for the channel frame parser. A byte stream of frames,
// broken frames and line noise is driven into the parser. Every accepted byte
// runs through a local parser model, which queues the channel values that a
// good end byte commits. Each result transfer is checked against that queue.
// ----------------------------------------------------------------------------
module tb_channel_frame_parser_core;

   localparam int CHANNELS = cfp_pkg::CHANNELS_DEFAULT;

   typedef struct packed {
      logic [4:0]  number;
      logic [11:0] value;
      logic        last;
   } channel_result_type;

   logic clock;
   logic reset;

   cfp_req_if req_if();
   cfp_rsp_if rsp_if();

   channel_frame_parser_core #(.CHANNELS(CHANNELS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // stimulus and expectations
   logic [7:0]         rx_byte_queue [$];
   channel_result_type committed_values [$];
   int                 queued_bytes;
   int                 error_count = 0;

   // control from the sequencing block
   bit  send_steady;
   bit  drain_steady;
   bit  hold_req;
   bit  hold_taken;
   int  hold_left;

   // parser model state
   cfp_pkg::parse_state_type frame_state;
   logic [3:0]               frame_nibble;
   logic [7:0]               frame_low;
   logic [4:0]               frame_channel;
   logic [4:0]               frame_count;
   logic [11:0]              model_values [CHANNELS];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void parse_rx_byte(input logic [7:0] b);
      channel_result_type r;
      case (frame_state)
         cfp_pkg::PARSE_HUNT: begin
            frame_state = (b == cfp_pkg::SOF_FIRST) ? cfp_pkg::PARSE_SECOND
                                                    : cfp_pkg::PARSE_ERROR;
         end
         cfp_pkg::PARSE_SECOND: begin
            frame_state = (b == cfp_pkg::SOF_SECOND) ? cfp_pkg::PARSE_COUNT
                                                     : cfp_pkg::PARSE_ERROR;
         end
         cfp_pkg::PARSE_COUNT: begin
            if (b == 8'd0)
               frame_count = 5'd1;
            else if (b > CHANNELS)
               frame_count = 5'(CHANNELS);
            else
               frame_count = b[4:0];
            frame_state = cfp_pkg::PARSE_HIGH;
         end
         cfp_pkg::PARSE_HIGH: begin
            frame_nibble = 4'(b & cfp_pkg::NIBBLE_MASK);
            frame_state = cfp_pkg::PARSE_LOW;
         end
         cfp_pkg::PARSE_LOW: begin
            frame_low = b;
            frame_state = cfp_pkg::PARSE_TRAILER;
         end
         cfp_pkg::PARSE_TRAILER: begin
            // value is stored even when the trailer turns out bad
            if (frame_channel < CHANNELS)
               model_values[frame_channel] = {frame_nibble, frame_low};
            frame_channel = frame_channel + 5'd1;
            frame_nibble = '0;
            frame_low = '0;
            if (frame_channel >= frame_count) begin
               frame_channel = '0;
               frame_state = cfp_pkg::PARSE_END;
            end else begin
               frame_state = (b == cfp_pkg::TRAILER_OK) ? cfp_pkg::PARSE_HIGH
                                                        : cfp_pkg::PARSE_ERROR;
            end
         end
         cfp_pkg::PARSE_END: begin
            if (b == cfp_pkg::EOF_BYTE) begin
               for (int i = 0; i < frame_count; i++) begin
                  r.number = 5'(i + 1);
                  r.value  = model_values[i];
                  r.last   = (i + 1 == frame_count);
                  committed_values.push_back(r);
               end
               frame_state = cfp_pkg::PARSE_HUNT;
            end else begin
               frame_state = cfp_pkg::PARSE_ERROR;
            end
         end
         default: begin
            // error state swallows this byte
            frame_nibble = '0;
            frame_low = '0;
            frame_channel = '0;
            frame_state = cfp_pkg::PARSE_HUNT;
         end
      endcase
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= '0;
         frame_state   = cfp_pkg::PARSE_HUNT;
         frame_nibble  = '0;
         frame_low     = '0;
         frame_channel = '0;
         frame_count   = '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid)
            parse_rx_byte(req_if.rx_byte);
         if (rx_byte_queue.size() > 0 && (send_steady || $urandom_range(0, 99) >= 31)) begin
            req_if.valid   <= 1'b1;
            req_if.rx_byte <= rx_byte_queue.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result ready, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_taken   <= 1'b0;
         hold_left    <= 0;
      end else if (hold_req && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= 400;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= drain_steady || ($urandom_range(0, 99) >= 31);
      end
   end

   // result monitor
   always @(posedge clock) begin
      channel_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (committed_values.size() == 0) begin
            $display("%0t: unexpected result ch %0d value %03h last %0b", $time,
                     rsp_if.channel_number, rsp_if.channel_value, rsp_if.last_channel);
            error_count++;
         end else begin
            want = committed_values.pop_front();
            if (rsp_if.channel_number !== want.number) begin
               $display("%0t: channel_number expected %0d actual %0d", $time,
                        want.number, rsp_if.channel_number);
               error_count++;
            end
            if (rsp_if.channel_value !== want.value) begin
               $display("%0t: channel_value expected %03h actual %03h", $time,
                        want.value, rsp_if.channel_value);
               error_count++;
            end
            if (rsp_if.last_channel !== want.last) begin
               $display("%0t: last_channel expected %0b actual %0b", $time,
                        want.last, rsp_if.last_channel);
               error_count++;
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      rx_byte_queue.push_back(b);
      queued_bytes++;
   endtask

   // any byte is fine here: it lands in the error state and is dropped
   task automatic queue_filler();
      queue_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic queue_noise();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      queue_byte(b);
      if (b == cfp_pkg::SOF_FIRST)
         queue_byte(8'h00);
      queue_filler();
   endtask

   // bad_at: channel whose trailer is corrupted, or -1 for none
   task automatic queue_frame(input logic [7:0] count_byte, input int bad_at,
                              input bit good_end);
      int         n;
      logic [7:0] b;
      n = (count_byte == 8'd0) ? 1 : ((count_byte > CHANNELS) ? CHANNELS : count_byte);
      queue_byte(cfp_pkg::SOF_FIRST);
      queue_byte(cfp_pkg::SOF_SECOND);
      queue_byte(count_byte);
      for (int k = 0; k < n; k++) begin
         queue_byte(8'($urandom_range(0, 255)));
         queue_byte(8'($urandom_range(0, 255)));
         if (k == n - 1) begin
            queue_byte($urandom_range(0, 1) ? cfp_pkg::TRAILER_OK
                                            : 8'($urandom_range(0, 255)));
         end else if (k == bad_at) begin
            do b = 8'($urandom_range(0, 255)); while (b == cfp_pkg::TRAILER_OK);
            queue_byte(b);
            queue_filler();
            return;
         end else begin
            queue_byte(cfp_pkg::TRAILER_OK);
         end
      end
      if (good_end) begin
         queue_byte(cfp_pkg::EOF_BYTE);
      end else begin
         do b = 8'($urandom_range(0, 255)); while (b == cfp_pkg::EOF_BYTE);
         queue_byte(b);
         queue_filler();
      end
   endtask

   function automatic logic [7:0] pick_count();
      if ($urandom_range(0, 11) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 4));
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (rx_byte_queue.size() > 0 || req_if.valid || committed_values.size() > 0);
   endtask

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [7:0] directed_bytes [];
      int r;

      directed_bytes = '{
         // wrong first byte, then discard
         8'h55, 8'h00,
         // wrong second byte
         cfp_pkg::SOF_FIRST, 8'h07, 8'hFF,
         // zero count
         cfp_pkg::SOF_FIRST, cfp_pkg::SOF_SECOND, 8'h00, 8'hFF, 8'hFF, 8'h33,
         cfp_pkg::EOF_BYTE,
         // bad trailer
         cfp_pkg::SOF_FIRST, cfp_pkg::SOF_SECOND, 8'h02, 8'hA5, 8'h5A, 8'h11,
         cfp_pkg::SOF_FIRST,
         // bad end byte
         cfp_pkg::SOF_FIRST, cfp_pkg::SOF_SECOND, 8'h01, 8'hF0, 8'h00,
         cfp_pkg::TRAILER_OK, 8'h00, cfp_pkg::EOF_BYTE
      };

      reset          = 1'b1;
      send_steady    = 1'b0;
      drain_steady   = 1'b0;
      hold_req       = 1'b0;
      queued_bytes   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (directed_bytes[i])
         queue_byte(directed_bytes[i]);
      wait_drained();

      // receiver stalls for a long stretch while frames keep arriving
      hold_req = 1'b1;
      for (int f = 0; f < 2; f++)
         queue_frame(8'd3, -1, 1'b1);
      wait_drained();

      // full-rate stretch on both sides with clamped counts, just above and
      // far above the channel limit
      send_steady  = 1'b1;
      drain_steady = 1'b1;
      queue_frame(8'(CHANNELS + 1), -1, 1'b1);
      queue_frame(8'hFF, -1, 1'b1);
      wait_drained();
      send_steady  = 1'b0;
      drain_steady = 1'b0;

      while (queued_bytes < 170) begin
         r = $urandom_range(0, 99);
         if (r < 75)
            queue_frame(pick_count(), -1, 1'b1);
         else if (r < 83)
            queue_frame(8'($urandom_range(2, 5)), $urandom_range(0, 3), 1'b1);
         else if (r < 90)
            queue_frame(pick_count(), -1, 1'b0);
         else
            queue_noise();
      end
      wait_drained();

      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
